// ===== rtl/core/rtw_pkg.sv =====
`timescale 1ns / 1ps

package rtw_pkg;

    localparam int MAX_WINDOW = 32;
    localparam int SEQ_BITS   = 30;
    localparam int MAX_LEN    = 1472;

    localparam int SLOT_W     = $clog2(MAX_WINDOW);
    localparam int LEN_W      = 11;
    localparam int WIN_W      = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 30;

    localparam logic [WIN_W-1:0]    WINDOW_RESET = WIN_W'(8);
    localparam logic [SEQ_BITS-1:0] INIT_RESET   = '0;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_INIT   = CFG_IDX_W'(2);

    typedef enum logic [2:0] {
        ACT_DROP    = 3'd0,
        ACT_DELIVER = 3'd1,
        ACT_STORE   = 3'd2,
        ACT_RELEASE = 3'd3,
        ACT_ACK     = 3'd4,
        ACT_FINISH  = 3'd5
    } t_action;

    typedef enum logic [2:0] {
        DEC_DROP,
        DEC_FINISH,
        DEC_DELIVER,
        DEC_IN_WINDOW,
        DEC_REACK
    } t_dec_kind;

    typedef struct packed {
        logic [SEQ_BITS-1:0] seq_num;
        logic [LEN_W-1:0]    length;
        logic                checksum_ok;
        logic                is_syn;
        logic                is_ack;
        logic                is_fin;
        logic                other_flags;
    } t_item;

    typedef struct packed {
        t_action             action;
        logic [SEQ_BITS-1:0] ack_seq;
        logic [SLOT_W-1:0]   slot;
        logic [LEN_W-1:0]    release_length;
        logic [SEQ_BITS-1:0] end_seq;
        logic                last;
    } t_result;

    typedef struct packed {
        t_dec_kind         kind;
        logic [SLOT_W-1:0] slot;
        logic              ahead_zero;
        logic              slot_busy;
    } t_decision;

endpackage

// ===== rtl/core/reliable_transfer_receiver_window.sv =====
`timescale 1ns / 1ps
// The header beat is registered and classified in the evaluate state, which writes the first
// result beat into the output register; further result beats come from the ack, store and
// release states, one beat a cycle while the output register can take it. A new header is
// taken only after the previous header's last result; the length memory is read ahead of use.
// Reset clears the window state, the slot valid bits and the finished flag; no clearing pass.

module reliable_transfer_receiver_window (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [rtw_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [rtw_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // seq_num[29:0], length[40:30], zero fill[47:41]
    input  logic [47:0]                       s_axis_tdata,
    // checksum_ok[0], is_syn[1], is_ack[2], is_fin[3], other_flags[4]
    input  logic [4:0]                        s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // ack_seq[29:0], slot[34:30], release_length[45:35], end_seq[75:46], zero fill[79:76]
    output logic [79:0]                       m_axis_tdata,
    // action[2:0]
    output logic [2:0]                        m_axis_tuser,
    output logic                              m_axis_tlast
);
    import rtw_pkg::*;

    logic                r_mode;
    logic [WIN_W-1:0]    r_window_size;
    logic                restart;
    t_item               item;
    logic                emit;
    logic                out_ready;
    t_result             emit_res;
    t_result             out_res;

    assign restart = i_cfg_we && (i_cfg_idx == CFG_INIT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= 1'b0;
            r_window_size <= WINDOW_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_MODE) begin
                r_mode <= i_cfg_data[0];
            end
            if (i_cfg_idx == CFG_WINDOW) begin
                r_window_size <= i_cfg_data[WIN_W-1:0];
            end
        end
    end

    always_comb begin
        item.seq_num     = s_axis_tdata[SEQ_BITS-1:0];
        item.length      = s_axis_tdata[SEQ_BITS+LEN_W-1:SEQ_BITS];
        item.checksum_ok = s_axis_tuser[0];
        item.is_syn      = s_axis_tuser[1];
        item.is_ack      = s_axis_tuser[2];
        item.is_fin      = s_axis_tuser[3];
        item.other_flags = s_axis_tuser[4];
    end

    rtw_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (s_axis_tvalid),
        .i_item        (item),
        .o_in_ready    (s_axis_tready),
        .i_mode        (r_mode),
        .i_window_size (r_window_size),
        .i_restart     (restart),
        .i_restart_seq (i_cfg_data[SEQ_BITS-1:0]),
        .o_emit        (emit),
        .o_res         (emit_res),
        .i_out_ready   (out_ready)
    );

    rtw_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (emit),
        .i_res   (emit_res),
        .o_ready (out_ready),
        .o_valid (m_axis_tvalid),
        .o_res   (out_res),
        .i_ready (m_axis_tready)
    );

    assign m_axis_tdata = {4'b0000, out_res.end_seq, out_res.release_length,
                           out_res.slot, out_res.ack_seq};
    assign m_axis_tuser = out_res.action;
    assign m_axis_tlast = out_res.last;

endmodule

// ===== rtl/core/rtw_classify.sv =====
`timescale 1ns / 1ps

module rtw_classify (
    input  rtw_pkg::t_item                      i_item,
    input  logic                                i_mode,
    input  logic [rtw_pkg::WIN_W-1:0]           i_window_size,
    input  logic [rtw_pkg::SEQ_BITS-1:0]        i_base_seq,
    input  logic [rtw_pkg::SLOT_W-1:0]          i_base_slot,
    input  logic [rtw_pkg::MAX_WINDOW-1:0]      i_slot_valid,
    input  logic                                i_finished,
    output rtw_pkg::t_decision                  o_dec
);
    import rtw_pkg::*;

    logic [WIN_W-1:0]    eff_w;
    logic [SEQ_BITS-1:0] ahead;
    logic [SEQ_BITS-1:0] behind;
    logic [SLOT_W-1:0]   slot;
    logic                drop;

    always_comb begin
        if (i_window_size == '0) begin
            eff_w = WIN_W'(1);
        end else if (i_window_size > WIN_W'(MAX_WINDOW)) begin
            eff_w = WIN_W'(MAX_WINDOW);
        end else begin
            eff_w = i_window_size;
        end
    end

    assign ahead  = i_item.seq_num - i_base_seq;
    assign behind = i_base_seq - i_item.seq_num;
    assign slot   = i_base_slot + ahead[SLOT_W-1:0];
    assign drop   = i_finished || (i_item.length > LEN_W'(MAX_LEN)) || !i_item.checksum_ok
                    || (i_item.length == '0) || i_item.is_syn || i_item.is_ack;

    always_comb begin
        o_dec.slot       = slot;
        o_dec.ahead_zero = (ahead == '0);
        o_dec.slot_busy  = i_slot_valid[slot];
        priority if (drop) begin
            o_dec.kind = DEC_DROP;
        end else if (i_item.is_fin && !i_item.other_flags) begin
            o_dec.kind = DEC_FINISH;
        end else if (!i_mode) begin
            o_dec.kind = (ahead == '0) ? DEC_DELIVER : DEC_DROP;
        end else if (ahead < SEQ_BITS'(eff_w)) begin
            o_dec.kind = DEC_IN_WINDOW;
        end else if (behind != '0 && behind <= SEQ_BITS'(eff_w)) begin
            o_dec.kind = DEC_REACK;
        end else begin
            o_dec.kind = DEC_DROP;
        end
    end

endmodule

// ===== rtl/core/rtw_out_reg.sv =====
`timescale 1ns / 1ps

module rtw_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  rtw_pkg::t_result  i_res,
    output logic              o_ready,
    output logic              o_valid,
    output rtw_pkg::t_result  o_res,
    input  logic              i_ready
);
    import rtw_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_res <= i_res;
        end
    end

endmodule

// ===== rtl/core/rtw_ctrl.sv =====
`timescale 1ns / 1ps

module rtw_ctrl (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  rtw_pkg::t_item                  i_item,
    output logic                            o_in_ready,
    input  logic                            i_mode,
    input  logic [rtw_pkg::WIN_W-1:0]       i_window_size,
    input  logic                            i_restart,
    input  logic [rtw_pkg::SEQ_BITS-1:0]    i_restart_seq,
    output logic                            o_emit,
    output rtw_pkg::t_result                o_res,
    input  logic                            i_out_ready
);
    import rtw_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_EVAL  = 5'b00010,
        ST_ACK   = 5'b00100,
        ST_STORE = 5'b01000,
        ST_REL   = 5'b10000
    } t_state;

    t_state                r_state, n_state;
    t_item                 r_item;
    logic [SEQ_BITS-1:0]   r_base_seq, n_base_seq;
    logic [SLOT_W-1:0]     r_base_slot, n_base_slot;
    logic [MAX_WINDOW-1:0] r_valid, n_valid;
    logic                  r_finished, n_finished;
    logic [SLOT_W-1:0]     r_slot, n_slot;
    logic                  r_az, n_az;
    logic                  r_byp;
    logic [LEN_W-1:0]      r_byp_data;
    logic [LEN_W-1:0]      r_mem_q;
    logic [LEN_W-1:0]      mem [MAX_WINDOW];
    logic [LEN_W-1:0]      rd_data;
    logic [SLOT_W-1:0]     next_slot;
    logic                  mem_we;
    t_decision             dec;
    t_result               res;

    rtw_classify u_classify (
        .i_item        (r_item),
        .i_mode        (i_mode),
        .i_window_size (i_window_size),
        .i_base_seq    (r_base_seq),
        .i_base_slot   (r_base_slot),
        .i_slot_valid  (r_valid),
        .i_finished    (r_finished),
        .o_dec         (dec)
    );

    assign o_in_ready = (r_state == ST_IDLE);
    assign rd_data    = r_byp ? r_byp_data : r_mem_q;
    assign next_slot  = r_base_slot + SLOT_W'(1);
    assign o_res      = res;

    always_comb begin
        n_state     = r_state;
        n_base_seq  = r_base_seq;
        n_base_slot = r_base_slot;
        n_valid     = r_valid;
        n_finished  = r_finished;
        n_slot      = r_slot;
        n_az        = r_az;
        mem_we      = 1'b0;
        o_emit      = 1'b0;
        res         = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (i_out_ready) begin
                    o_emit = 1'b1;
                    unique case (dec.kind)
                        DEC_FINISH: begin
                            n_finished  = 1'b1;
                            res.action  = ACT_FINISH;
                            res.end_seq = i_mode ? r_item.seq_num : r_base_seq;
                            res.last    = 1'b1;
                            n_state     = ST_IDLE;
                        end
                        DEC_DELIVER: begin
                            res.action           = ACT_DELIVER;
                            n_valid[r_base_slot] = 1'b0;
                            n_base_slot          = next_slot;
                            n_base_seq           = r_base_seq + SEQ_BITS'(1);
                            n_state              = ST_ACK;
                        end
                        DEC_IN_WINDOW: begin
                            res.action  = ACT_ACK;
                            res.ack_seq = r_item.seq_num;
                            res.last    = dec.slot_busy;
                            n_slot      = dec.slot;
                            n_az        = dec.ahead_zero;
                            n_state     = dec.slot_busy ? ST_IDLE : ST_STORE;
                        end
                        DEC_REACK: begin
                            res.action  = ACT_ACK;
                            res.ack_seq = r_item.seq_num;
                            res.last    = 1'b1;
                            n_state     = ST_IDLE;
                        end
                        default: begin
                            res.action = ACT_DROP;
                            res.last   = 1'b1;
                            n_state    = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_ACK: begin
                if (i_out_ready) begin
                    o_emit      = 1'b1;
                    res.action  = ACT_ACK;
                    res.ack_seq = r_base_seq;
                    res.last    = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            ST_STORE: begin
                if (i_out_ready) begin
                    o_emit          = 1'b1;
                    res.action      = ACT_STORE;
                    res.slot        = r_slot;
                    res.last        = !r_az;
                    n_valid[r_slot] = 1'b1;
                    mem_we          = 1'b1;
                    n_state         = r_az ? ST_REL : ST_IDLE;
                end
            end
            ST_REL: begin
                if (i_out_ready) begin
                    o_emit               = 1'b1;
                    res.action           = ACT_RELEASE;
                    res.slot             = r_base_slot;
                    res.release_length   = rd_data;
                    res.last             = !r_valid[next_slot];
                    n_valid[r_base_slot] = 1'b0;
                    n_base_slot          = next_slot;
                    n_base_seq           = r_base_seq + SEQ_BITS'(1);
                    n_state              = r_valid[next_slot] ? ST_REL : ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        if (i_restart) begin
            n_base_seq  = i_restart_seq;
            n_base_slot = '0;
            n_valid     = '0;
            n_finished  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_base_seq  <= INIT_RESET;
            r_base_slot <= '0;
            r_valid     <= '0;
            r_finished  <= 1'b0;
            r_byp       <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_base_seq  <= n_base_seq;
            r_base_slot <= n_base_slot;
            r_valid     <= n_valid;
            r_finished  <= n_finished;
            r_byp       <= mem_we && (r_slot == n_base_slot);
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_item <= i_item;
        end
        r_slot     <= n_slot;
        r_az       <= n_az;
        r_byp_data <= r_item.length;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_slot] <= r_item.length;
        end
        r_mem_q <= mem[n_base_slot];
    end

endmodule
